>>> sv/rbs_pkg.sv
// rbs_pkg: shared widths, config register codes and pipeline item types
// for the ray/box slab intersection pipeline; no dependencies
package rbs_pkg;

  localparam int CW  = 32;        // coordinate width
  localparam int FB  = 16;        // fraction bits, must not exceed CW
  localparam int NAX = 3;         // axes
  localparam int NLN = 2 * NAX;   // divider lanes, low and high edge per axis

  typedef logic [CW-1:0]        word_t;
  typedef logic signed [CW-1:0] sword_t;
  typedef logic [CW-2:0]        half_t;

  // configuration register indexes
  localparam logic CFG_BOX_HALF  = 1'b0;
  localparam logic CFG_BOX_VALID = 1'b1;

  localparam sword_t T_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam sword_t T_MAX = {1'b0, {(CW-1){1'b1}}};

  // one divider lane in flight
  typedef struct packed {
    word_t r;     // partial remainder
    word_t n;     // dividend bits still to shift in
    word_t q;     // quotient so far
    word_t dm;    // divisor magnitude
    logic  neg;   // quotient sign
    logic  ovf;   // quotient at least 2^CW
  } lane_t;

  typedef struct packed {
    logic [NAX-1:0] zero_d;
    logic [NAX-1:0] outside;
    sword_t         md;
  } side_t;

  typedef struct packed {
    lane_t [NLN-1:0] lane;
    side_t           side;
  } div_item_t;

endpackage

>>> sv/ray_box_slab_intersect.sv
// ray_box_slab_intersect: top level of the ray against origin-centred cube
// slab test; depends on rbs_pkg, rbs_front, rbs_div_step and rbs_back
// item path: rbs_front stages, the rbs_div_step chain, then rbs_back stages
// throughput: one ray per cycle while out_ready is high; every stage then takes a new item each cycle
// each stage holds its item under backpressure; bubbles are squeezed out
// reset: synchronous active-low rst_n clears all stage valid bits and
// the box registers (half extent 0, box not valid)
module ray_box_slab_intersect (
  input  logic            clk,
  input  logic            rst_n,
  // ray items
  input  logic            in_valid,
  output logic            in_ready,
  input  rbs_pkg::sword_t in_origin_x,
  input  rbs_pkg::sword_t in_origin_y,
  input  rbs_pkg::sword_t in_origin_z,
  input  rbs_pkg::sword_t in_dir_x,
  input  rbs_pkg::sword_t in_dir_y,
  input  rbs_pkg::sword_t in_dir_z,
  input  rbs_pkg::sword_t in_max_dist,
  // result items
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_hit,
  output rbs_pkg::sword_t out_hit_dist,
  // configuration writes
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_index,
  input  rbs_pkg::half_t  cfg_data
);

  rbs_pkg::half_t                     half_r;
  logic                               box_valid_r;
  rbs_pkg::sword_t [rbs_pkg::NAX-1:0] orig, dir;

  // handshake and item chain through the division steps
  logic               chain_v   [rbs_pkg::CW+1];
  logic               chain_rdy [rbs_pkg::CW+1];
  rbs_pkg::div_item_t chain_d   [rbs_pkg::CW+1];

  assign orig = {in_origin_z, in_origin_y, in_origin_x};
  assign dir  = {in_dir_z, in_dir_y, in_dir_x};

  // config is always taken; the sender writes only while the pipe is idle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r      <= '0;
      box_valid_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        rbs_pkg::CFG_BOX_HALF:  half_r      <= cfg_data;
        rbs_pkg::CFG_BOX_VALID: box_valid_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // numerators, divisor magnitudes, overflow check
  rbs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .orig     (orig),
    .dir      (dir),
    .max_dist (in_max_dist),
    .half     (half_r),
    .dn_valid (chain_v[0]),
    .dn_ready (chain_rdy[0]),
    .dn_item  (chain_d[0])
  );

  // one quotient bit per stage, all six slab lanes side by side
  for (genvar i = 0; i < rbs_pkg::CW; i++) begin : g_step
    rbs_div_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (chain_v[i]),
      .up_ready (chain_rdy[i]),
      .up_item  (chain_d[i]),
      .dn_valid (chain_v[i+1]),
      .dn_ready (chain_rdy[i+1]),
      .dn_item  (chain_d[i+1])
    );
  end

  // saturation, interval reduction and the hit decision
  rbs_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (chain_v[rbs_pkg::CW]),
    .up_ready     (chain_rdy[rbs_pkg::CW]),
    .up_item      (chain_d[rbs_pkg::CW]),
    .box_valid    (box_valid_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_hit      (out_hit),
    .out_hit_dist (out_hit_dist)
  );

  // a box that is not set up never reports a hit
  a_no_box_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !box_valid_r) |-> !out_hit)
    else $error("hit reported without a valid box");

  // a miss always carries distance zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_hit_dist == '0))
    else $error("miss with non-zero distance");

  // a hit is never behind the origin
  a_hit_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (out_hit_dist >= 0))
    else $error("hit distance negative");

  // stall at the output holds the last division stage
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (chain_v[rbs_pkg::CW] && !chain_rdy[rbs_pkg::CW]) |=> chain_v[rbs_pkg::CW])
    else $error("item dropped under stall");

endmodule

>>> sv/rbs_front.sv
// rbs_front: two register stages forming slab numerators, divisor
// magnitudes and overflow flags; depends on rbs_pkg
module rbs_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               up_valid,
  output logic                               up_ready,
  input  rbs_pkg::sword_t [rbs_pkg::NAX-1:0] orig,
  input  rbs_pkg::sword_t [rbs_pkg::NAX-1:0] dir,
  input  rbs_pkg::sword_t                    max_dist,
  input  rbs_pkg::half_t                     half,
  output logic                               dn_valid,
  input  logic                               dn_ready,
  output rbs_pkg::div_item_t                 dn_item
);

  logic                                s1_v_r, s2_v_r;
  logic                                s1_ld, s2_ld;
  rbs_pkg::word_t [rbs_pkg::NLN-1:0]   nm_r, nm_nxt;
  rbs_pkg::word_t [rbs_pkg::NAX-1:0]   dm_r, dm_nxt;
  logic [rbs_pkg::NLN-1:0]             neg_r, neg_nxt;
  rbs_pkg::side_t                      side_r, side_nxt;
  rbs_pkg::div_item_t                  item_r, item_nxt;

  assign s2_ld    = !s2_v_r || dn_ready;
  assign s1_ld    = !s1_v_r || s2_ld;
  assign up_ready = s1_ld;
  assign dn_valid = s2_v_r;
  assign dn_item  = item_r;

  // stage one: edge minus origin, magnitudes and signs
  always_comb begin
    logic signed [rbs_pkg::CW:0] h_e, o_e, edge_v, diff_v, ndiff_v;
    logic                        dneg;
    side_nxt.md = max_dist;
    h_e = {2'b00, half};
    for (int a = 0; a < rbs_pkg::NAX; a++) begin
      dneg      = dir[a][rbs_pkg::CW-1];
      dm_nxt[a] = dneg ? (~dir[a] + 1'b1) : dir[a];
      o_e       = {orig[a][rbs_pkg::CW-1], orig[a]};
      side_nxt.zero_d[a]  = (dir[a] == '0);
      side_nxt.outside[a] = (o_e < -h_e) || (o_e > h_e);
      for (int e = 0; e < 2; e++) begin
        edge_v  = (e == 0) ? -h_e : h_e;
        diff_v  = edge_v - o_e;
        ndiff_v = -diff_v;
        nm_nxt[2*a+e]  = diff_v[rbs_pkg::CW] ? ndiff_v[rbs_pkg::CW-1:0]
                                             : diff_v[rbs_pkg::CW-1:0];
        neg_nxt[2*a+e] = diff_v[rbs_pkg::CW] ^ dneg;
      end
    end
  end

  // stage two: aligned dividend, overflow test, first remainder
  always_comb begin
    logic [2*rbs_pkg::CW-1:0] n_ext, d_ext;
    item_nxt.side = side_r;
    for (int k = 0; k < rbs_pkg::NLN; k++) begin
      n_ext = {{(rbs_pkg::CW-rbs_pkg::FB){1'b0}}, nm_r[k], {rbs_pkg::FB{1'b0}}};
      d_ext = {dm_r[k/2], {rbs_pkg::CW{1'b0}}};
      item_nxt.lane[k].ovf = (n_ext >= d_ext);
      item_nxt.lane[k].r   = n_ext[2*rbs_pkg::CW-1:rbs_pkg::CW];
      item_nxt.lane[k].n   = n_ext[rbs_pkg::CW-1:0];
      item_nxt.lane[k].q   = '0;
      item_nxt.lane[k].dm  = dm_r[k/2];
      item_nxt.lane[k].neg = neg_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_ld) s1_v_r <= up_valid;
      if (s2_ld) s2_v_r <= s1_v_r;
    end
    if (s1_ld) begin
      nm_r   <= nm_nxt;
      dm_r   <= dm_nxt;
      neg_r  <= neg_nxt;
      side_r <= side_nxt;
    end
    if (s2_ld) item_r <= item_nxt;
  end

endmodule

>>> sv/rbs_div_step.sv
// rbs_div_step: one restoring division step on all six lanes, one
// register stage with handshake; depends on rbs_pkg
module rbs_div_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  rbs_pkg::div_item_t up_item,
  output logic               dn_valid,
  input  logic               dn_ready,
  output rbs_pkg::div_item_t dn_item
);

  logic               v_r, ld;
  rbs_pkg::div_item_t item_r, item_nxt;

  assign ld       = !v_r || dn_ready;
  assign up_ready = ld;
  assign dn_valid = v_r;
  assign dn_item  = item_r;

  always_comb begin
    logic [rbs_pkg::CW:0] r2, diff;
    logic                 ge;
    item_nxt = up_item;
    for (int k = 0; k < rbs_pkg::NLN; k++) begin
      r2   = {up_item.lane[k].r, up_item.lane[k].n[rbs_pkg::CW-1]};
      diff = r2 - {1'b0, up_item.lane[k].dm};
      ge   = (r2 >= {1'b0, up_item.lane[k].dm});
      item_nxt.lane[k].r = ge ? diff[rbs_pkg::CW-1:0] : r2[rbs_pkg::CW-1:0];
      item_nxt.lane[k].n = {up_item.lane[k].n[rbs_pkg::CW-2:0], 1'b0};
      item_nxt.lane[k].q = {up_item.lane[k].q[rbs_pkg::CW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ld) begin
      v_r <= up_valid;
    end
    if (ld) item_r <= item_nxt;
  end

endmodule

>>> sv/rbs_back.sv
// rbs_back: saturation, per-axis interval, interval reduction and hit
// decision with the output register; depends on rbs_pkg
module rbs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  rbs_pkg::div_item_t up_item,
  input  logic               box_valid,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_hit,
  output rbs_pkg::sword_t    out_hit_dist
);

  logic                               s_v_r, f1_v_r, f2_v_r, o_v_r;
  logic                               s_ld, f1_ld, f2_ld, o_ld;
  rbs_pkg::sword_t [rbs_pkg::NLN-1:0] t_r, t_nxt;
  rbs_pkg::side_t                     side_r;
  rbs_pkg::sword_t [rbs_pkg::NAX-1:0] lo_r, hi_r, lo_nxt, hi_nxt;
  logic [rbs_pkg::NAX-1:0]            use_r;
  logic                               miss1_r, miss1_nxt;
  rbs_pkg::sword_t                    md1_r, md2_r;
  rbs_pkg::sword_t                    tmin_r, tmax_r, tmin_nxt, tmax_nxt;
  logic                               miss2_r;
  logic                               hit_r, hit_nxt;
  rbs_pkg::sword_t                    dist_r, dist_nxt;

  assign o_ld     = !o_v_r || out_ready;
  assign f2_ld    = !f2_v_r || o_ld;
  assign f1_ld    = !f1_v_r || f2_ld;
  assign s_ld     = !s_v_r || f1_ld;
  assign up_ready = s_ld;

  assign out_valid    = o_v_r;
  assign out_hit      = hit_r;
  assign out_hit_dist = dist_r;

  // saturate quotient magnitude and apply sign
  always_comb begin
    rbs_pkg::word_t lim, mag, ng;
    for (int k = 0; k < rbs_pkg::NLN; k++) begin
      lim = up_item.lane[k].neg ? rbs_pkg::word_t'(rbs_pkg::T_MIN)
                                : rbs_pkg::word_t'(rbs_pkg::T_MAX);
      mag = (up_item.lane[k].ovf || up_item.lane[k].q > lim) ? lim
                                                             : up_item.lane[k].q;
      ng  = ~mag + 1'b1;
      t_nxt[k] = up_item.lane[k].neg ? rbs_pkg::sword_t'(ng) : rbs_pkg::sword_t'(mag);
    end
  end

  // per-axis near/far ordering and zero-direction misses
  always_comb begin
    miss1_nxt = 1'b0;
    for (int a = 0; a < rbs_pkg::NAX; a++) begin
      lo_nxt[a] = (t_r[2*a] < t_r[2*a+1]) ? t_r[2*a] : t_r[2*a+1];
      hi_nxt[a] = (t_r[2*a] < t_r[2*a+1]) ? t_r[2*a+1] : t_r[2*a];
      if (side_r.zero_d[a] && side_r.outside[a]) miss1_nxt = 1'b1;
    end
  end

  // entry is the latest near distance, exit the earliest far distance
  always_comb begin
    tmin_nxt = rbs_pkg::T_MIN;
    tmax_nxt = rbs_pkg::T_MAX;
    for (int a = 0; a < rbs_pkg::NAX; a++) begin
      if (use_r[a] && lo_r[a] > tmin_nxt) tmin_nxt = lo_r[a];
      if (use_r[a] && hi_r[a] < tmax_nxt) tmax_nxt = hi_r[a];
    end
  end

  always_comb begin
    rbs_pkg::sword_t hd;
    logic            miss;
    hd   = (tmin_r >= 0) ? tmin_r : tmax_r;
    miss = miss2_r || !box_valid || (tmax_r < 0) || (tmin_r > tmax_r)
           || (tmin_r > md2_r) || (hd > md2_r);
    hit_nxt  = !miss;
    dist_nxt = miss ? '0 : hd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r  <= 1'b0;
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (s_ld)  s_v_r  <= up_valid;
      if (f1_ld) f1_v_r <= s_v_r;
      if (f2_ld) f2_v_r <= f1_v_r;
      if (o_ld)  o_v_r  <= f2_v_r;
    end
    if (s_ld) begin
      t_r    <= t_nxt;
      side_r <= up_item.side;
    end
    if (f1_ld) begin
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
      use_r   <= ~side_r.zero_d;
      miss1_r <= miss1_nxt;
      md1_r   <= side_r.md;
    end
    if (f2_ld) begin
      tmin_r  <= tmin_nxt;
      tmax_r  <= tmax_nxt;
      miss2_r <= miss1_r || (use_r == '0);
      md2_r   <= md1_r;
    end
    if (o_ld) begin
      hit_r  <= hit_nxt;
      dist_r <= dist_nxt;
    end
  end

endmodule
